/* src/ezr_pkg.sv */
package ezr_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int PHASE_WIDTH  = 32;
    localparam int TRIG_WIDTH   = 34;
    localparam int ZACC_WIDTH   = 34;
    localparam int TRIG_FRAC    = 30;
    localparam int GAIN_INIT    = 652032874;
    localparam int ROT_STAGES   = 3;
    localparam logic [PHASE_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [PHASE_WIDTH-1:0] HALF_TURN    = 32'h8000_0000;

    // arctan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_step(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/ezr_if.sv */
interface ezr_in_if #(
    parameter int CW = ezr_pkg::COORD_WIDTH,
    parameter int AW = ezr_pkg::ANGLE_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] shift_x;
    logic signed [CW-1:0] shift_y;
    logic signed [CW-1:0] shift_z;
    logic signed [AW-1:0] angle_about_x;
    logic signed [AW-1:0] angle_about_y;
    logic signed [AW-1:0] angle_about_z;

    modport source (
        output valid, point_x, point_y, point_z, shift_x, shift_y, shift_z,
               angle_about_x, angle_about_y, angle_about_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, shift_x, shift_y, shift_z,
               angle_about_x, angle_about_y, angle_about_z,
        output ready
    );
endinterface

interface ezr_out_if #(
    parameter int CW = ezr_pkg::COORD_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] moved_x;
    logic signed [CW-1:0] moved_y;
    logic signed [CW-1:0] moved_z;

    modport source (output valid, moved_x, moved_y, moved_z, input ready);
    modport sink (input valid, moved_x, moved_y, moved_z, output ready);
endinterface

/* src/ezr_cordic_cell.sv */
module ezr_cordic_cell #(
    parameter int STEP = 0,
    parameter int PW   = 192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [3*(2*ezr_pkg::TRIG_WIDTH+ezr_pkg::ZACC_WIDTH+1)-1:0] i_lanes,
    input  logic [PW-1:0] i_pass,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [3*(2*ezr_pkg::TRIG_WIDTH+ezr_pkg::ZACC_WIDTH+1)-1:0] o_lanes,
    output logic [PW-1:0] o_pass
);
    localparam int TW = ezr_pkg::TRIG_WIDTH;
    localparam int ZW = ezr_pkg::ZACC_WIDTH;
    localparam int LW = 2*TW + ZW + 1;

    logic                r_valid;
    logic [3*LW-1:0]     r_lanes;
    logic [PW-1:0]       r_pass;
    logic [3*LW-1:0]     n_lanes;
    logic signed [ZW-1:0] w_atan;

    assign w_atan  = $signed(ZW'(ezr_pkg::atan_step(STEP)));
    assign o_ready = !r_valid || i_ready;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [TW-1:0] x, y, nx, ny;
        logic signed [ZW-1:0] z, nz;
        assign x = $signed(i_lanes[k*LW +: TW]);
        assign y = $signed(i_lanes[k*LW+TW +: TW]);
        assign z = $signed(i_lanes[k*LW+2*TW +: ZW]);
        always_comb begin
            if (!z[ZW-1]) begin
                nx = x - (y >>> STEP);
                ny = y + (x >>> STEP);
                nz = z - w_atan;
            end else begin
                nx = x + (y >>> STEP);
                ny = y - (x >>> STEP);
                nz = z + w_atan;
            end
        end
        assign n_lanes[k*LW +: LW] = {i_lanes[k*LW+LW-1], nz, ny, nx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_lanes <= n_lanes;
            r_pass  <= i_pass;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;
    assign o_pass  = r_pass;
endmodule

/* src/ezr_rot_cell.sv */
module ezr_rot_cell #(
    parameter int RW = 34,
    parameter int PW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [RW-1:0] i_a,
    input  logic signed [RW-1:0] i_b,
    input  logic signed [ezr_pkg::TRIG_WIDTH-1:0] i_c,
    input  logic signed [ezr_pkg::TRIG_WIDTH-1:0] i_s,
    input  logic [PW-1:0]        i_pass,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [RW-1:0] o_a,
    output logic signed [RW-1:0] o_b,
    output logic [PW-1:0]        o_pass
);
    // a' = a*c - b*s, b' = a*s + b*c, rounded half up from Q4.30
    localparam int TW = ezr_pkg::TRIG_WIDTH;
    localparam int LO = RW / 2;
    localparam int HW = RW - LO;
    localparam int PH = HW + TW;
    localparam int PL = LO + 1 + TW;
    localparam int SW = RW + TW + 2;
    localparam int FR = ezr_pkg::TRIG_FRAC;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FR - 1);

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    logic signed [HW-1:0] w_ah, w_bh;
    logic signed [LO:0]   w_al, w_bl;
    logic signed [PH-1:0] r_ahc, r_bhs, r_ahs, r_bhc;
    logic signed [PL-1:0] r_alc, r_bls, r_als, r_blc;
    logic [PW-1:0]        r_p1, r_p2, r_p3;
    logic signed [SW-1:0] r_u, r_v;
    logic signed [SW-1:0] n_u, n_v, w_ur, w_vr;
    logic signed [RW-1:0] r_a, r_b;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_ah = $signed(i_a[RW-1:LO]);
    assign w_bh = $signed(i_b[RW-1:LO]);
    assign w_al = $signed({1'b0, i_a[LO-1:0]});
    assign w_bl = $signed({1'b0, i_b[LO-1:0]});

    always_comb begin
        n_u = ((SW'(r_ahc) - SW'(r_bhs)) <<< LO) + SW'(r_alc) - SW'(r_bls);
        n_v = ((SW'(r_ahs) + SW'(r_bhc)) <<< LO) + SW'(r_als) + SW'(r_blc);
    end

    assign w_ur = (r_u + HALF) >>> FR;
    assign w_vr = (r_v + HALF) >>> FR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_ahc <= PH'(w_ah) * PH'(i_c);
            r_bhs <= PH'(w_bh) * PH'(i_s);
            r_ahs <= PH'(w_ah) * PH'(i_s);
            r_bhc <= PH'(w_bh) * PH'(i_c);
            r_alc <= PL'(w_al) * PL'(i_c);
            r_bls <= PL'(w_bl) * PL'(i_s);
            r_als <= PL'(w_al) * PL'(i_s);
            r_blc <= PL'(w_bl) * PL'(i_c);
            r_p1  <= i_pass;
        end
        if (w_rdy2) begin
            r_u  <= n_u;
            r_v  <= n_v;
            r_p2 <= r_p1;
        end
        if (w_rdy3) begin
            r_a  <= w_ur[RW-1:0];
            r_b  <= w_vr[RW-1:0];
            r_p3 <= r_p2;
        end
    end

    assign o_valid = r_v3;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_pass  = r_p3;
endmodule

/* src/euler_zxy_rotate_translate.sv */
// Moves a Q16.16 point by rotating it about z, then x, then y, and adding a
// translation, with results saturated to COORD_WIDTH bits. Fully pipelined:
// one request per cycle while not full (30 CORDIC cells computing all three
// sines and cosines side by side, three rotation cells of 3 stages each built
// around split multipliers, and the saturating output register). Every stage
// holds its own valid bit, so bubbles close up while the output is stalled.
module euler_zxy_rotate_translate #(
    parameter int COORD_WIDTH = ezr_pkg::COORD_WIDTH,
    parameter int ANGLE_WIDTH = ezr_pkg::ANGLE_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ezr_in_if.sink     i_in,
    ezr_out_if.source  o_out
);
    localparam int CW    = COORD_WIDTH;
    localparam int AW    = ANGLE_WIDTH;
    localparam int RW    = CW + 2;
    localparam int TW    = ezr_pkg::TRIG_WIDTH;
    localparam int ZW    = ezr_pkg::ZACC_WIDTH;
    localparam int PHW   = ezr_pkg::PHASE_WIDTH;
    localparam int LW    = 2*TW + ZW + 1;
    localparam int NS    = ezr_pkg::CORDIC_STEPS;
    localparam int PW0   = 6*CW;
    localparam int PWZ   = RW + 3*CW + 4*TW;
    localparam int PWX   = RW + 3*CW + 2*TW;
    localparam int PWY   = RW + 3*CW;
    localparam int DEPTH = NS + 3*ezr_pkg::ROT_STAGES + 1;
    localparam int OCW   = $clog2(DEPTH + 1);

    // ---- phase setup, lanes: 0 = z angle, 1 = x angle, 2 = y angle
    logic [AW-1:0]   w_ang [3];
    logic [3*LW-1:0] w_lane0;

    assign w_ang[0] = i_in.angle_about_z;
    assign w_ang[1] = i_in.angle_about_x;
    assign w_ang[2] = i_in.angle_about_y;

    for (genvar k = 0; k < 3; k++) begin : g_prep
        logic [PHW-1:0] ph, q, ph2;
        logic           neg;
        assign ph  = {w_ang[k], (PHW-AW)'(0)};
        assign q   = ph + ezr_pkg::QUARTER_TURN;
        assign neg = q[PHW-1];
        assign ph2 = neg ? ph + ezr_pkg::HALF_TURN : ph;
        assign w_lane0[k*LW +: LW] = {neg, ZW'($signed(ph2)), TW'(0),
                                      TW'(ezr_pkg::GAIN_INIT)};
    end

    // ---- CORDIC chain
    logic            w_cv [NS+1];
    logic            w_cr [NS+1];
    logic [3*LW-1:0] w_cl [NS+1];
    logic [PW0-1:0]  w_cp [NS+1];

    assign w_cv[0]    = i_in.valid;
    assign i_in.ready = w_cr[0];
    assign w_cl[0]    = w_lane0;
    assign w_cp[0]    = {i_in.shift_z, i_in.shift_y, i_in.shift_x,
                         i_in.point_z, i_in.point_y, i_in.point_x};

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        ezr_cordic_cell #(.STEP(i), .PW(PW0)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[i]),
            .o_ready (w_cr[i]),
            .i_lanes (w_cl[i]),
            .i_pass  (w_cp[i]),
            .o_valid (w_cv[i+1]),
            .i_ready (w_cr[i+1]),
            .o_lanes (w_cl[i+1]),
            .o_pass  (w_cp[i+1])
        );
    end

    // final sign fix of the trig values
    logic signed [TW-1:0] w_cos [3];
    logic signed [TW-1:0] w_sin [3];
    for (genvar k = 0; k < 3; k++) begin : g_trig
        logic signed [TW-1:0] x, y;
        logic                 neg;
        assign x   = $signed(w_cl[NS][k*LW +: TW]);
        assign y   = $signed(w_cl[NS][k*LW+TW +: TW]);
        assign neg = w_cl[NS][k*LW+LW-1];
        assign w_cos[k] = neg ? -x : x;
        assign w_sin[k] = neg ? -y : y;
    end

    logic signed [CW-1:0] w_px, w_py, w_pz;
    logic [3*CW-1:0]      w_shifts;
    assign w_px     = $signed(w_cp[NS][0 +: CW]);
    assign w_py     = $signed(w_cp[NS][CW +: CW]);
    assign w_pz     = $signed(w_cp[NS][2*CW +: CW]);
    assign w_shifts = w_cp[NS][3*CW +: 3*CW];

    // ---- rotation about z on (x, y)
    logic                 w_zv, w_zr;
    logic signed [RW-1:0] w_zx, w_zy;
    logic [PWZ-1:0]       w_zp;

    ezr_rot_cell #(.RW(RW), .PW(PWZ)) u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cv[NS]),
        .o_ready (w_cr[NS]),
        .i_a     (RW'(w_px)),
        .i_b     (RW'(w_py)),
        .i_c     (w_cos[0]),
        .i_s     (w_sin[0]),
        .i_pass  ({w_sin[2], w_cos[2], w_sin[1], w_cos[1], w_shifts, RW'(w_pz)}),
        .o_valid (w_zv),
        .i_ready (w_zr),
        .o_a     (w_zx),
        .o_b     (w_zy),
        .o_pass  (w_zp)
    );

    // ---- rotation about x on (y, z)
    logic                 w_xv, w_xr;
    logic signed [RW-1:0] w_xy, w_xz;
    logic [PWX-1:0]       w_xp;

    ezr_rot_cell #(.RW(RW), .PW(PWX)) u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_zv),
        .o_ready (w_zr),
        .i_a     (w_zy),
        .i_b     ($signed(w_zp[RW-1:0])),
        .i_c     ($signed(w_zp[RW+3*CW +: TW])),
        .i_s     ($signed(w_zp[RW+3*CW+TW +: TW])),
        .i_pass  ({w_zp[RW+3*CW+2*TW +: 2*TW], w_zp[RW +: 3*CW], w_zx}),
        .o_valid (w_xv),
        .i_ready (w_xr),
        .o_a     (w_xy),
        .o_b     (w_xz),
        .o_pass  (w_xp)
    );

    // ---- rotation about y on (z, x)
    logic                 w_yv, w_yr;
    logic signed [RW-1:0] w_yz, w_yx;
    logic [PWY-1:0]       w_yp;

    ezr_rot_cell #(.RW(RW), .PW(PWY)) u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xv),
        .o_ready (w_xr),
        .i_a     (w_xz),
        .i_b     ($signed(w_xp[RW-1:0])),
        .i_c     ($signed(w_xp[RW+3*CW +: TW])),
        .i_s     ($signed(w_xp[RW+3*CW+TW +: TW])),
        .i_pass  ({w_xp[RW +: 3*CW], w_xy}),
        .o_valid (w_yv),
        .i_ready (w_yr),
        .o_a     (w_yz),
        .o_b     (w_yx),
        .o_pass  (w_yp)
    );

    // ---- translate and saturate
    logic signed [RW-1:0] w_fin [3];
    logic signed [CW-1:0] w_sat [3];
    assign w_fin[0] = w_yx;
    assign w_fin[1] = $signed(w_yp[RW-1:0]);
    assign w_fin[2] = w_yz;

    for (genvar k = 0; k < 3; k++) begin : g_sat
        logic signed [RW:0] s;
        assign s = (RW+1)'(w_fin[k]) + (RW+1)'($signed(w_yp[RW+k*CW +: CW]));
        always_comb begin
            if (s[RW:CW-1] == '0 || s[RW:CW-1] == '1) begin
                w_sat[k] = s[CW-1:0];
            end else if (s[RW]) begin
                w_sat[k] = {1'b1, (CW-1)'(0)};
            end else begin
                w_sat[k] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    logic                 r_out_valid;
    logic signed [CW-1:0] r_mx, r_my, r_mz;

    assign w_yr = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_yr) begin
            r_out_valid <= w_yv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_yr) begin
            r_mx <= w_sat[0];
            r_my <= w_sat[1];
            r_mz <= w_sat[2];
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.moved_x = r_mx;
    assign o_out.moved_y = r_my;
    assign o_out.moved_z = r_mz;

    // ---- occupancy, checked only
    logic [OCW-1:0] r_occ;
    logic           w_in_acc, w_out_acc;
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_occ <= r_occ + OCW'(1);
        end else if (!w_in_acc && w_out_acc) begin
            r_occ <= r_occ - OCW'(1);
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_valid && !o_out.ready && r_occ == OCW'(DEPTH)))
        else $error("input stalled with room in the pipeline");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCW'(DEPTH))
        else $error("more requests in flight than stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == '0 |-> !o_out.valid)
        else $error("result without a pending request");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
endmodule
